// ===== sv/ckre_pkg.sv =====
// shared types and constants for the color key run extractor
package ckre_pkg;

  // field widths of the channels and registers
  localparam int PIX_W   = 24;
  localparam int SIZE_W  = 13;
  localparam int LEFT_W  = 12;
  localparam int RIGHT_W = 13;
  localparam int ROW_W   = 12;
  localparam int TOTAL_W = 24;
  localparam int IDX_W   = 2;

  // saturation point of the run counter
  localparam logic [TOTAL_W-1:0] RUN_LIMIT = 24'd8388608;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_KEY_COLOR = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_MONO      = 2'd3
  } reg_idx_t;

  // result kinds
  typedef enum logic {
    KIND_RUN = 1'b0,
    KIND_SUM = 1'b1
  } kind_t;

  // results caused by one pixel: a run record and/or a frame summary
  typedef struct packed {
    logic               rec_valid;
    logic               sum_valid;
    logic [LEFT_W-1:0]  left;
    logic [RIGHT_W-1:0] right;
    logic [ROW_W-1:0]   row;
    logic [TOTAL_W-1:0] total;
    logic               saw;
  } res_t;

endpackage

// ===== sv/ckre_outbuf.sv =====
// two-slot result buffer: run record first, then frame summary
module ckre_outbuf (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  ckre_pkg::res_t           res,
  output logic                     ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     kind,
  output logic [ckre_pkg::LEFT_W-1:0]  run_left,
  output logic [ckre_pkg::RIGHT_W-1:0] run_right,
  output logic [ckre_pkg::ROW_W-1:0]   run_row,
  output logic [ckre_pkg::TOTAL_W-1:0] run_total,
  output logic                     saw_transparent,
  output logic                     last
);
  import ckre_pkg::*;

  logic               rec_pend;
  logic               sum_pend;
  logic [LEFT_W-1:0]  buf_left;
  logic [RIGHT_W-1:0] buf_right;
  logic [ROW_W-1:0]   buf_row;
  logic [TOTAL_W-1:0] buf_total;
  logic               buf_saw;
  logic               out_take;

  assign out_take = out_valid && !out_stall;

  // free for a new item once at most one result is left and it goes now
  assign ready = !(rec_pend || sum_pend) || (out_take && !(rec_pend && sum_pend));

  // pending flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_pend <= 1'b0;
      sum_pend <= 1'b0;
    end else if (load) begin
      rec_pend <= res.rec_valid;
      sum_pend <= res.sum_valid;
    end else if (out_take) begin
      if (rec_pend) begin
        rec_pend <= 1'b0;
      end else begin
        sum_pend <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      buf_left  <= res.left;
      buf_right <= res.right;
      buf_row   <= res.row;
      buf_total <= res.total;
      buf_saw   <= res.saw;
    end
  end

  // output selection
  always_comb begin
    out_valid       = rec_pend || sum_pend;
    kind            = rec_pend ? KIND_RUN : KIND_SUM;
    run_left        = rec_pend ? buf_left  : '0;
    run_right       = rec_pend ? buf_right : '0;
    run_row         = rec_pend ? buf_row   : '0;
    run_total       = rec_pend ? '0 : buf_total;
    saw_transparent = rec_pend ? 1'b0 : buf_saw;
    last            = !(rec_pend && sum_pend);
  end

endmodule

// ===== sv/color_key_run_extractor.sv =====
// top level of the color key run extractor
//
// Pixels come in raster order on the input channel (in_valid, in_stall,
// pixel), one per item. Each horizontal run of opaque pixels leaves on the
// output channel as a run record (kind 0: left, exclusive right, row) when a
// transparent pixel or the row end closes it; after the last pixel of the
// frame a summary (kind 1) carries the run count and the transparent flag.
// The field last marks the final result caused by one pixel.
// A pixel is registered, then its results are registered in the result buffer.
// Throughput: one pixel per cycle while its results can be placed; a pixel that
// causes both a run record and a summary fills both slots of the result buffer.
// When the receiver stalls, results hold in the buffer; pixels that cause no
// result still pass, and the input stalls once a result cannot be placed.
// Configuration is written through wr_en/wr_index/wr_data while idle.
// Reset (rst, synchronous) restores the register defaults (key 0, size
// 4096 x 4096, color-key mode), clears all counters and empties both stages.
module color_key_run_extractor #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [ckre_pkg::IDX_W-1:0]    wr_index,
  input  logic [ckre_pkg::PIX_W-1:0]    wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ckre_pkg::PIX_W-1:0]    pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [ckre_pkg::LEFT_W-1:0]   run_left,
  output logic [ckre_pkg::RIGHT_W-1:0]  run_right,
  output logic [ckre_pkg::ROW_W-1:0]    run_row,
  output logic [ckre_pkg::TOTAL_W-1:0]  run_total,
  output logic                          saw_transparent,
  output logic                          last
);
  import ckre_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // configuration registers
  logic [PIX_W-1:0]  key_color;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic              mono_mode;

  // frame state
  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  logic               run_open;
  logic [CW-1:0]      run_start;
  logic [TOTAL_W-1:0] runs;
  logic               seen;

  // input register
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic             s1_adv;
  logic             in_take;

  // per-pixel logic
  logic [SIZE_W-1:0]  w_eff;
  logic [SIZE_W-1:0]  h_eff;
  logic               transp;
  logic               open_after;
  logic [CW-1:0]      start_after;
  logic               seen_after;
  logic               row_end;
  logic               frame_end;
  logic [TOTAL_W-1:0] runs_after;
  res_t               res;
  logic               buf_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_color    <= '0;
      image_width  <= SIZE_W'(4096);
      image_height <= SIZE_W'(4096);
      mono_mode    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_KEY_COLOR: key_color    <= wr_data;
        REG_WIDTH:     image_width  <= wr_data[SIZE_W-1:0];
        REG_HEIGHT:    image_height <= wr_data[SIZE_W-1:0];
        REG_MONO:      mono_mode    <= wr_data[0];
        default:       ;
      endcase
    end
  end

  // input handshake and register
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pixel <= pixel;
    end
  end

  // clamp the image size to 1..max
  always_comb begin
    if (image_width == '0) begin
      w_eff = SIZE_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = SIZE_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // classify the pixel, close and open runs
  always_comb begin
    transp      = mono_mode ? s1_pixel[0] : (s1_pixel == key_color);
    res         = '0;
    open_after  = run_open;
    start_after = run_start;
    seen_after  = seen || transp;
    res.right   = RIGHT_W'(col);
    if (transp) begin
      res.rec_valid = run_open;
      open_after    = 1'b0;
    end else if (!run_open) begin
      open_after  = 1'b1;
      start_after = col;
    end

    row_end   = 32'(col) >= (32'(w_eff) - 32'd1);
    frame_end = row_end && (32'(row) >= (32'(h_eff) - 32'd1));
    if (row_end && open_after) begin
      res.rec_valid = 1'b1;
      res.right     = w_eff;
      open_after    = 1'b0;
    end

    runs_after = (res.rec_valid && (runs < RUN_LIMIT)) ? runs + 1'b1 : runs;

    res.left      = LEFT_W'(start_after);
    res.row       = ROW_W'(row);
    res.sum_valid = frame_end;
    res.total     = runs_after;
    res.saw       = seen_after;
  end

  // a pixel moves on when its results fit, or when it has none
  assign s1_adv = s1_valid && (buf_ready || !(res.rec_valid || res.sum_valid));

  // counters and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      run_open  <= 1'b0;
      run_start <= '0;
      runs      <= '0;
      seen      <= 1'b0;
    end else if (s1_adv) begin
      col <= row_end ? '0 : col + 1'b1;
      if (row_end) begin
        row <= frame_end ? '0 : row + 1'b1;
      end
      run_open  <= frame_end ? 1'b0 : open_after;
      run_start <= frame_end ? '0 : start_after;
      runs      <= frame_end ? '0 : runs_after;
      seen      <= frame_end ? 1'b0 : seen_after;
    end
  end

  // result buffer
  ckre_outbuf u_outbuf (
    .clk             (clk),
    .rst             (rst),
    .load            (s1_adv && (res.rec_valid || res.sum_valid)),
    .res             (res),
    .ready           (buf_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .run_left        (run_left),
    .run_right       (run_right),
    .run_row         (run_row),
    .run_total       (run_total),
    .saw_transparent (saw_transparent),
    .last            (last)
  );

  // a frame summary always ends the results of its pixel
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_SUM) |-> last)
    else $error("summary item not marked last");

  // the run counter never passes its saturation point
  assert property (@(posedge clk) disable iff (rst)
    runs <= RUN_LIMIT)
    else $error("run counter above limit");

  // a held pixel with results only waits while the buffer is busy
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> (out_valid && !buf_ready))
    else $error("pixel held with free result buffer");

endmodule

// ===== verif/color_key_run_extractor_test.sv =====
// testbench for the color key run extractor: random and directed pixels against a run tracker
`timescale 1ns / 100ps

module color_key_run_extractor_test;
  import ckre_pkg::*;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE       = 6;
  localparam int IDLE_PCT     = 23;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 113;

  // one result as it leaves the block
  typedef struct packed {
    kind_t              kind;
    logic [LEFT_W-1:0]  left;
    logic [RIGHT_W-1:0] right;
    logic [ROW_W-1:0]   row;
    logic [TOTAL_W-1:0] total;
    logic               saw;
    logic               last;
  } run_result_t;

  // tracks runs and frame summaries and holds the results still to come
  class run_tracker;
    logic [PIX_W-1:0]   key;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic               mono;
    logic [LEFT_W-1:0]  col;
    logic [ROW_W-1:0]   row;
    logic               in_run;
    logic [LEFT_W-1:0]  run_from;
    logic [TOTAL_W-1:0] run_count;
    logic               any_clear;
    run_result_t        awaited[$];
    int                 mismatches;

    function new();
      key        = '0;
      width_reg  = SIZE_W'(MAX_WIDTH);
      height_reg = SIZE_W'(MAX_HEIGHT);
      mono       = 1'b0;
      col        = '0;
      row        = '0;
      in_run     = 1'b0;
      run_from   = '0;
      run_count  = '0;
      any_clear  = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [PIX_W-1:0] value);
      case (idx)
        REG_KEY_COLOR: key = value;
        REG_WIDTH:     width_reg = value[SIZE_W-1:0];
        REG_HEIGHT:    height_reg = value[SIZE_W-1:0];
        REG_MONO:      mono = value[0];
        default:       ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // out-of-range sizes act as the nearest legal one
    function int clamp(logic [SIZE_W-1:0] v, int cap);
      if (v == 0) return 1;
      if (int'(v) > cap) return cap;
      return int'(v);
    endfunction

    function void emit_run(int right_edge);
      run_result_t r;
      r = '{kind: KIND_RUN, left: run_from, right: RIGHT_W'(right_edge), row: row,
            total: '0, saw: 1'b0, last: 1'b0};
      awaited.push_back(r);
      in_run = 1'b0;
      if (run_count < RUN_LIMIT) run_count++;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] p);
      int          w;
      int          h;
      int          queued;
      logic        clear;
      run_result_t r;
      w      = clamp(width_reg, MAX_WIDTH);
      h      = clamp(height_reg, MAX_HEIGHT);
      queued = awaited.size();
      clear  = mono ? p[0] : (p == key);

      // a transparent pixel closes the open run, an opaque one may open one
      if (clear) begin
        any_clear = 1'b1;
        if (in_run) emit_run(int'(col));
      end else if (!in_run) begin
        in_run   = 1'b1;
        run_from = col;
      end

      // row end, then frame end
      if (int'(col) >= w - 1) begin
        if (in_run) emit_run(w);
        col = '0;
        if (int'(row) >= h - 1) begin
          r = '{kind: KIND_SUM, left: '0, right: '0, row: '0, total: run_count,
                saw: any_clear, last: 1'b0};
          awaited.push_back(r);
          row       = '0;
          in_run    = 1'b0;
          run_from  = '0;
          run_count = '0;
          any_clear = 1'b0;
        end else begin
          row++;
        end
      end else begin
        col++;
      end

      if (awaited.size() > queued) awaited[$].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(run_result_t got);
      run_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result kind %0d left %0d right %0d row %0d total %0d",
                 $time, got.kind, got.left, got.right, got.row, got.total);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("run_left", want.left, got.left);
      compare_field("run_right", want.right, got.right);
      compare_field("run_row", want.row, got.row);
      compare_field("run_total", want.total, got.total);
      compare_field("saw_transparent", want.saw, got.saw);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                wr_en = 1'b0;
  logic [IDX_W-1:0]    wr_index = '0;
  logic [PIX_W-1:0]    wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PIX_W-1:0]    pixel = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                kind;
  logic [LEFT_W-1:0]   run_left;
  logic [RIGHT_W-1:0]  run_right;
  logic [ROW_W-1:0]    run_row;
  logic [TOTAL_W-1:0]  run_total;
  logic                saw_transparent;
  logic                last;

  run_tracker runs = new();
  bit         steady = 1'b0;
  int         cycle_count = 0;

  color_key_run_extractor #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .run_left(run_left),
    .run_right(run_right),
    .run_row(run_row),
    .run_total(run_total),
    .saw_transparent(saw_transparent),
    .last(last)
  );

  always #4 clk = ~clk;

  function automatic bit quiet();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= quiet();
  end

  // every accepted result goes to the tracker
  always @(posedge clk) begin
    run_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{kind: kind_t'(kind), left: run_left, right: run_right, row: run_row,
              total: run_total, saw: saw_transparent, last: last};
      runs.check_result(got);
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [PIX_W-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    runs.set_reg(idx, value);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // offer one item, with random gaps, and hold it until taken
  task automatic send_pixel(logic [PIX_W-1:0] p);
    while (quiet()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    do @(posedge clk); while (in_stall);
    runs.note_pixel(p);
  endtask

  // stop sending, wait for every result, then let the pipeline empty
  task automatic go_idle();
    in_valid <= 1'b0;
    while (runs.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // pixel with roughly clear_pct percent transparent, near misses of the key included
  function automatic logic [PIX_W-1:0] random_pixel(int clear_pct);
    logic [PIX_W-1:0] p;
    p = PIX_W'($urandom);
    if (runs.mono) begin
      p[0] = ($urandom_range(0, 99) < clear_pct);
    end else if ($urandom_range(0, 99) < clear_pct) begin
      p = runs.key;
    end else if ($urandom_range(0, 4) == 0) begin
      p = runs.key ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
    end
    return p;
  endfunction

  initial begin
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    int                clear_pct;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // two-row frame: runs closed by transparent pixels and by the row end
    write_reg(REG_KEY_COLOR, 24'h123456);
    write_reg(REG_WIDTH, 24'd5);
    write_reg(REG_HEIGHT, 24'd2);
    send_pixel(24'h123456);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h123456);
    send_pixel(24'hABCDEF);
    repeat (5) send_pixel(24'hEDCBA9);
    go_idle();

    // one-pixel frames: summary alone, run plus summary
    write_reg(REG_KEY_COLOR, 24'hFFFFFF);
    write_reg(REG_WIDTH, 24'd1);
    write_reg(REG_HEIGHT, 24'd1);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    go_idle();

    // mono mode ignores the key; zero sizes act as one
    write_reg(REG_MONO, 24'd1);
    write_reg(REG_WIDTH, 24'd0);
    write_reg(REG_HEIGHT, 24'd0);
    send_pixel(24'h000001);
    send_pixel(24'hFFFFFE);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    go_idle();

    // oversized height clamps; shrinking it below the current row ends the frame
    write_reg(REG_MONO, 24'd0);
    write_reg(REG_KEY_COLOR, 24'h000000);
    write_reg(REG_WIDTH, 24'd1);
    write_reg(REG_HEIGHT, 24'h001FFF);
    repeat (40) send_pixel(random_pixel(10));
    go_idle();
    write_reg(REG_HEIGHT, 24'd2);
    send_pixel(random_pixel(10));
    go_idle();

    // oversized width clamps; shrinking it below the current column ends the row
    write_reg(REG_WIDTH, 24'h001FFF);
    write_reg(REG_HEIGHT, 24'd1);
    repeat (60) send_pixel(random_pixel(3));
    go_idle();
    write_reg(REG_WIDTH, 24'd3);
    send_pixel(random_pixel(3));
    go_idle();

    // random phases with random settings; sizes may change mid-frame
    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph == 3);
      case ($urandom_range(0, 3))
        0:       write_reg(REG_KEY_COLOR, 24'h000000);
        1:       write_reg(REG_KEY_COLOR, 24'hFFFFFF);
        default: write_reg(REG_KEY_COLOR, PIX_W'($urandom));
      endcase
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = '1;
        default: w = SIZE_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       h = '0;
        1:       h = '1;
        default: h = SIZE_W'($urandom_range(1, 6));
      endcase
      // upper bits of the write data carry junk the block must drop
      write_reg(REG_WIDTH, {11'($urandom), w});
      write_reg(REG_HEIGHT, {11'($urandom), h});
      write_reg(REG_MONO, {23'($urandom), 1'($urandom_range(0, 99) < 30)});
      clear_pct = $urandom_range(10, 60);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender holds off until the block has drained
        if (ph == 6 && i == PHASE_ITEMS / 2) go_idle();
        send_pixel(random_pixel(clear_pct));
      end
      go_idle();
    end

    if (runs.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
